// ----- rtl/rai_pkg.sv -----
`timescale 1ns / 1ps
package rai_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CRD_W     = 32;
  localparam int NUM_W     = CRD_W + 1;
  localparam int SH_W      = NUM_W + FRAC_BITS;
  localparam int TQ_W      = 32;
  localparam int TOP_W     = SH_W - TQ_W;
  localparam int T_W       = TQ_W + 2;
  localparam int PROD_W    = 2 * CRD_W;
  localparam int PT_W      = PROD_W - FRAC_BITS + 1;
  localparam int TEX_FRAC  = 16;
  localparam int TEX_W     = TEX_FRAC + 1;
  localparam int MAT_W     = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int AXIS_W    = 2;

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_Z = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_X = 2'd2
  } axis_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_AXIS   = 3'd0,
    REG_PLANE_OFFSET = 3'd1,
    REG_A_LOW        = 3'd2,
    REG_A_HIGH       = 3'd3,
    REG_B_LOW        = 3'd4,
    REG_B_HIGH       = 3'd5,
    REG_MATERIAL     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    crd_t              offset;
    crd_t              a_low;
    crd_t              a_high;
    crd_t              b_low;
    crd_t              b_high;
    logic [MAT_W-1:0]  material;
  } cfg_t;

  // ray data carried alongside the t divider
  typedef struct packed {
    crd_t ox;
    crd_t oy;
    crd_t oz;
    crd_t dx;
    crd_t dy;
    crd_t dz;
    crd_t tmin;
    crd_t tmax;
    logic neg;
    logic front;
    logic miss;
  } ray_side_t;

  // hit data carried alongside the texture dividers
  typedef struct packed {
    logic hit;
    logic front;
    crd_t t;
    crd_t px;
    crd_t py;
    crd_t pz;
  } hit_side_t;

endpackage

// ----- rtl/ray_axis_rect_intersect.sv -----
`timescale 1ns / 1ps
// Ray against axis-aligned rectangle, fully pipelined. One ray transaction can
// be issued every clock cycle (busy is never raised); each one yields exactly
// one result on out_* 54 cycles after the start edge (taken at the 55th edge),
// marked by a one-cycle out_valid strobe that the receiver must take. The
// latency is set by the t divider (one quotient bit per stage, 32 stages) and
// the two texture dividers (one bit per stage, 17 stages), plus setup,
// interval test, multiply, point add/bounds and output stages. On a miss every
// result field is zero. Coordinates are signed Q16.16; tex_u/tex_v are Q0.16
// where 65536 is 1.0. Configuration registers take effect on the following
// edge and must only be written with no transaction in flight.
module ray_axis_rect_intersect (
  input  logic                              clk,
  input  logic                              rst_n,
  // ray input
  input  logic                              start,
  output logic                              busy,
  input  logic signed [rai_pkg::CRD_W-1:0]  in_origin_x,
  input  logic signed [rai_pkg::CRD_W-1:0]  in_origin_y,
  input  logic signed [rai_pkg::CRD_W-1:0]  in_origin_z,
  input  logic signed [rai_pkg::CRD_W-1:0]  in_dir_x,
  input  logic signed [rai_pkg::CRD_W-1:0]  in_dir_y,
  input  logic signed [rai_pkg::CRD_W-1:0]  in_dir_z,
  input  logic signed [rai_pkg::CRD_W-1:0]  in_t_min,
  input  logic signed [rai_pkg::CRD_W-1:0]  in_t_max,
  // result
  output logic                              out_valid,
  output logic                              out_hit,
  output logic signed [rai_pkg::CRD_W-1:0]  out_hit_t,
  output logic [rai_pkg::TEX_W-1:0]         out_tex_u,
  output logic [rai_pkg::TEX_W-1:0]         out_tex_v,
  output logic signed [rai_pkg::CRD_W-1:0]  out_point_x,
  output logic signed [rai_pkg::CRD_W-1:0]  out_point_y,
  output logic signed [rai_pkg::CRD_W-1:0]  out_point_z,
  output logic                              out_front_face,
  output logic [rai_pkg::MAT_W-1:0]         out_material,
  // configuration
  input  logic                              cfg_we,
  input  logic [rai_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [rai_pkg::CFG_W-1:0]         cfg_wdata
);

  rai_pkg::cfg_t cfg_r, cfg_nxt;

  // register file; unknown indexes are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (rai_pkg::cfg_reg_t'(cfg_idx))
        rai_pkg::REG_PLANE_AXIS:   cfg_nxt.axis     = cfg_wdata[rai_pkg::AXIS_W-1:0];
        rai_pkg::REG_PLANE_OFFSET: cfg_nxt.offset   = cfg_wdata[rai_pkg::CRD_W-1:0];
        rai_pkg::REG_A_LOW:        cfg_nxt.a_low    = cfg_wdata[rai_pkg::CRD_W-1:0];
        rai_pkg::REG_A_HIGH:       cfg_nxt.a_high   = cfg_wdata[rai_pkg::CRD_W-1:0];
        rai_pkg::REG_B_LOW:        cfg_nxt.b_low    = cfg_wdata[rai_pkg::CRD_W-1:0];
        rai_pkg::REG_B_HIGH:       cfg_nxt.b_high   = cfg_wdata[rai_pkg::CRD_W-1:0];
        rai_pkg::REG_MATERIAL:     cfg_nxt.material = cfg_wdata[rai_pkg::MAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // the pipeline never stalls, so a new transaction is always taken
  assign busy = 1'b0;

  // setup: plane distance numerator, divisor, early miss
  logic                             s_vld;
  rai_pkg::ray_side_t               s_side;
  logic [rai_pkg::SH_W-1:0]         s_dvd;
  logic [rai_pkg::CRD_W-1:0]        s_dvs;

  rai_setup u_setup (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_in (start),
    .ox     (in_origin_x),
    .oy     (in_origin_y),
    .oz     (in_origin_z),
    .dx     (in_dir_x),
    .dy     (in_dir_y),
    .dz     (in_dir_z),
    .tmin   (in_t_min),
    .tmax   (in_t_max),
    .cfg    (cfg_r),
    .vld_r  (s_vld),
    .side_r (s_side),
    .dvd_r  (s_dvd),
    .dvs_r  (s_dvs)
  );

  // t = |num| * 2^FRAC / |dir_n|, truncated; overflow flag for |t| >= 2^32
  logic                             d_vld, d_ovf;
  rai_pkg::ray_side_t               d_side;
  logic [rai_pkg::TQ_W-1:0]         d_q;

  rai_tdiv u_tdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (s_vld),
    .side_in (s_side),
    .dvd_in  (s_dvd),
    .dvs_in  (s_dvs),
    .vld_o   (d_vld),
    .side_o  (d_side),
    .q_o     (d_q),
    .ovf_o   (d_ovf)
  );

  // interval test, hit point, rectangle bounds
  logic                             h_vld;
  rai_pkg::hit_side_t               h_hs;
  logic [rai_pkg::CRD_W-1:0]        h_xa, h_ea, h_xb, h_eb;

  rai_hitpt u_hitpt (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (d_vld),
    .side_in (d_side),
    .q_in    (d_q),
    .ovf_in  (d_ovf),
    .cfg     (cfg_r),
    .vld_o   (h_vld),
    .hs_o    (h_hs),
    .xa_o    (h_xa),
    .ea_o    (h_ea),
    .xb_o    (h_xb),
    .eb_o    (h_eb)
  );

  // texture coordinates: (p - low) * 65536 / (high - low)
  logic                             x_vld;
  rai_pkg::hit_side_t               x_hs;
  logic [rai_pkg::TEX_W-1:0]        x_u, x_v;

  rai_texdiv u_texdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_in (h_vld),
    .hs_in  (h_hs),
    .xa_in  (h_xa),
    .ea_in  (h_ea),
    .xb_in  (h_xb),
    .eb_in  (h_eb),
    .vld_o  (x_vld),
    .hs_o   (x_hs),
    .u_o    (x_u),
    .v_o    (x_v)
  );

  // output register; a miss zeroes every field
  logic take;
  assign take = x_vld && x_hs.hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid      <= 1'b0;
      out_hit        <= 1'b0;
      out_hit_t      <= '0;
      out_tex_u      <= '0;
      out_tex_v      <= '0;
      out_point_x    <= '0;
      out_point_y    <= '0;
      out_point_z    <= '0;
      out_front_face <= 1'b0;
      out_material   <= '0;
    end else begin
      out_valid      <= x_vld;
      out_hit        <= take;
      out_hit_t      <= take ? x_hs.t  : '0;
      out_tex_u      <= take ? x_u     : '0;
      out_tex_v      <= take ? x_v     : '0;
      out_point_x    <= take ? x_hs.px : '0;
      out_point_y    <= take ? x_hs.py : '0;
      out_point_z    <= take ? x_hs.pz : '0;
      out_front_face <= take && x_hs.front;
      out_material   <= take ? cfg_r.material : '0;
    end
  end

  // a hit only comes with a result strobe
  a_hit_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    out_hit |-> out_valid)
    else $error("hit without result strobe");

  // texture coordinates never exceed 1.0 on a hit
  a_tex_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_hit |-> (out_tex_u <= rai_pkg::TEX_W'(1 << rai_pkg::TEX_FRAC))
             && (out_tex_v <= rai_pkg::TEX_W'(1 << rai_pkg::TEX_FRAC)))
    else $error("texture coordinate above 1.0");

  // a miss carries all-zero fields
  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    !out_hit |-> (out_hit_t == '0) && (out_tex_u == '0) && (out_tex_v == '0)
              && (out_point_x == '0) && (out_point_y == '0) && (out_point_z == '0)
              && !out_front_face && (out_material == '0))
    else $error("miss with nonzero fields");

  // hit material matches the programmed tag
  a_material : assert property (@(posedge clk) disable iff (!rst_n)
    out_hit |-> (out_material == $past(cfg_r.material)))
    else $error("material mismatch on hit");

endmodule

// ----- rtl/rai_setup.sv -----
`timescale 1ns / 1ps
module rai_setup (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld_in,
  input  rai_pkg::crd_t              ox,
  input  rai_pkg::crd_t              oy,
  input  rai_pkg::crd_t              oz,
  input  rai_pkg::crd_t              dx,
  input  rai_pkg::crd_t              dy,
  input  rai_pkg::crd_t              dz,
  input  rai_pkg::crd_t              tmin,
  input  rai_pkg::crd_t              tmax,
  input  rai_pkg::cfg_t              cfg,
  output logic                       vld_r,
  output rai_pkg::ray_side_t         side_r,
  output logic [rai_pkg::SH_W-1:0]   dvd_r,
  output logic [rai_pkg::CRD_W-1:0]  dvs_r
);

  rai_pkg::crd_t                     on, dn;
  logic                              bad_axis;
  logic signed [rai_pkg::NUM_W-1:0]  num;
  logic [rai_pkg::NUM_W-1:0]         mag;
  rai_pkg::ray_side_t                side_nxt;
  logic [rai_pkg::SH_W-1:0]          dvd_nxt;
  logic [rai_pkg::CRD_W-1:0]         dvs_nxt;

  always_comb begin
    bad_axis = 1'b0;
    case (rai_pkg::axis_t'(cfg.axis))
      rai_pkg::AXIS_Z: begin
        on = oz;
        dn = dz;
      end
      rai_pkg::AXIS_Y: begin
        on = oy;
        dn = dy;
      end
      rai_pkg::AXIS_X: begin
        on = ox;
        dn = dx;
      end
      default: begin
        on       = oz;
        dn       = dz;
        bad_axis = 1'b1;
      end
    endcase

    num     = $signed({cfg.offset[rai_pkg::CRD_W-1], cfg.offset})
            - $signed({on[rai_pkg::CRD_W-1], on});
    mag     = num[rai_pkg::NUM_W-1] ? rai_pkg::NUM_W'(-num) : rai_pkg::NUM_W'(num);
    dvd_nxt = {mag, {rai_pkg::FRAC_BITS{1'b0}}};
    dvs_nxt = dn[rai_pkg::CRD_W-1] ? rai_pkg::CRD_W'(-dn) : rai_pkg::CRD_W'(dn);

    side_nxt.ox    = ox;
    side_nxt.oy    = oy;
    side_nxt.oz    = oz;
    side_nxt.dx    = dx;
    side_nxt.dy    = dy;
    side_nxt.dz    = dz;
    side_nxt.tmin  = tmin;
    side_nxt.tmax  = tmax;
    side_nxt.neg   = num[rai_pkg::NUM_W-1] ^ dn[rai_pkg::CRD_W-1];
    side_nxt.front = dn[rai_pkg::CRD_W-1];
    side_nxt.miss  = bad_axis || (dn == '0)
                  || (cfg.a_high <= cfg.a_low) || (cfg.b_high <= cfg.b_low);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    side_r <= side_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
  end

endmodule

// ----- rtl/rai_tdiv.sv -----
`timescale 1ns / 1ps
module rai_tdiv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld_in,
  input  rai_pkg::ray_side_t         side_in,
  input  logic [rai_pkg::SH_W-1:0]   dvd_in,
  input  logic [rai_pkg::CRD_W-1:0]  dvs_in,
  output logic                       vld_o,
  output rai_pkg::ray_side_t         side_o,
  output logic [rai_pkg::TQ_W-1:0]   q_o,
  output logic                       ovf_o
);

  localparam int N = rai_pkg::TQ_W;

  logic [N-1:0]              vld_r;
  logic [rai_pkg::CRD_W-1:0] rem_r   [N];
  logic [rai_pkg::CRD_W-1:0] rem_nxt [N];
  logic [N-1:0]              lo_r    [N];
  logic [N-1:0]              lo_nxt  [N];
  logic [N-1:0]              q_r     [N];
  logic [N-1:0]              q_nxt   [N];
  logic [rai_pkg::CRD_W-1:0] dvs_r   [N];
  logic                      ovf_r   [N];
  rai_pkg::ray_side_t        side_r  [N];

  // one quotient bit per stage, restoring division
  always_comb begin
    logic [rai_pkg::CRD_W-1:0] rem_i;
    logic [N-1:0]              lo_i;
    logic [N-1:0]              q_i;
    logic [rai_pkg::CRD_W-1:0] dvs_i;
    logic [rai_pkg::CRD_W:0]   r2;
    logic                      ge;
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        rem_i = rai_pkg::CRD_W'(dvd_in[rai_pkg::SH_W-1:N]);
        lo_i  = dvd_in[N-1:0];
        q_i   = '0;
        dvs_i = dvs_in;
      end else begin
        rem_i = rem_r[i-1];
        lo_i  = lo_r[i-1];
        q_i   = q_r[i-1];
        dvs_i = dvs_r[i-1];
      end
      r2         = {rem_i, lo_i[N-1]};
      ge         = r2 >= {1'b0, dvs_i};
      rem_nxt[i] = ge ? rai_pkg::CRD_W'(r2 - {1'b0, dvs_i}) : r2[rai_pkg::CRD_W-1:0];
      lo_nxt[i]  = lo_i << 1;
      q_nxt[i]   = {q_i[N-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N-2:0], vld_in};
    end
    for (int i = 0; i < N; i++) begin
      rem_r[i] <= rem_nxt[i];
      lo_r[i]  <= lo_nxt[i];
      q_r[i]   <= q_nxt[i];
    end
    // quotient would need more than N bits: never inside a 32-bit t interval
    ovf_r[0]  <= rai_pkg::CRD_W'(dvd_in[rai_pkg::SH_W-1:N]) >= dvs_in;
    dvs_r[0]  <= dvs_in;
    side_r[0] <= side_in;
    for (int i = 1; i < N; i++) begin
      ovf_r[i]  <= ovf_r[i-1];
      dvs_r[i]  <= dvs_r[i-1];
      side_r[i] <= side_r[i-1];
    end
  end

  assign vld_o  = vld_r[N-1];
  assign side_o = side_r[N-1];
  assign q_o    = q_r[N-1];
  assign ovf_o  = ovf_r[N-1];

endmodule

// ----- rtl/rai_hitpt.sv -----
`timescale 1ns / 1ps
module rai_hitpt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld_in,
  input  rai_pkg::ray_side_t         side_in,
  input  logic [rai_pkg::TQ_W-1:0]   q_in,
  input  logic                       ovf_in,
  input  rai_pkg::cfg_t              cfg,
  output logic                       vld_o,
  output rai_pkg::hit_side_t         hs_o,
  output logic [rai_pkg::CRD_W-1:0]  xa_o,
  output logic [rai_pkg::CRD_W-1:0]  ea_o,
  output logic [rai_pkg::CRD_W-1:0]  xb_o,
  output logic [rai_pkg::CRD_W-1:0]  eb_o
);

  localparam int PT_W = rai_pkg::PT_W;

  function automatic rai_pkg::crd_t sat_pt(input logic signed [PT_W-1:0] v);
    logic signed [PT_W-1:0] hi;
    logic signed [PT_W-1:0] lo;
    hi = PT_W'($signed({1'b0, {(rai_pkg::CRD_W-1){1'b1}}}));
    lo = PT_W'($signed({1'b1, {(rai_pkg::CRD_W-1){1'b0}}}));
    if (v > hi) begin
      return hi[rai_pkg::CRD_W-1:0];
    end else if (v < lo) begin
      return lo[rai_pkg::CRD_W-1:0];
    end
    return v[rai_pkg::CRD_W-1:0];
  endfunction

  // stage A: signed t, interval test
  logic                               vld_a_r, miss_a_r;
  rai_pkg::crd_t                      t_a_r;
  rai_pkg::ray_side_t                 side_a_r;
  logic signed [rai_pkg::T_W-1:0]     t_full, t_mag;
  logic                               in_rng;

  always_comb begin
    t_mag  = $signed({2'b00, q_in});
    t_full = side_in.neg ? -t_mag : t_mag;
    in_rng = !ovf_in
          && (t_full >= rai_pkg::T_W'($signed(side_in.tmin)))
          && (t_full <= rai_pkg::T_W'($signed(side_in.tmax)));
  end

  // stage B: t * dir on all three axes
  logic                               vld_b_r, miss_b_r;
  rai_pkg::crd_t                      t_b_r;
  rai_pkg::ray_side_t                 side_b_r;
  logic signed [rai_pkg::PROD_W-1:0]  prx_b_r, pry_b_r, prz_b_r;

  // stage C: point = origin + floor(product / 2^FRAC_BITS)
  logic                               vld_c_r, miss_c_r;
  rai_pkg::crd_t                      t_c_r;
  logic                               front_c_r;
  logic signed [PT_W-1:0]             px_c_r, py_c_r, pz_c_r;

  function automatic logic signed [PT_W-1:0] add_pt(input rai_pkg::crd_t o,
      input logic signed [rai_pkg::PROD_W-1:0] pr);
    logic signed [rai_pkg::PROD_W-1:0] sh;
    sh = pr >>> rai_pkg::FRAC_BITS;
    return PT_W'($signed(o)) + $signed(sh[PT_W-1:0]);
  endfunction

  // stage D: bound tests and texture numerators
  logic signed [PT_W-1:0]             pa, pb, da, db;
  logic                               in_rect;
  logic [rai_pkg::CRD_W:0]            ext_a, ext_b;
  rai_pkg::hit_side_t                 hs_nxt;

  always_comb begin
    case (rai_pkg::axis_t'(cfg.axis))
      rai_pkg::AXIS_Z: begin
        pa = px_c_r;
        pb = py_c_r;
      end
      rai_pkg::AXIS_Y: begin
        pa = px_c_r;
        pb = pz_c_r;
      end
      default: begin
        pa = py_c_r;
        pb = pz_c_r;
      end
    endcase
    in_rect = (pa >= PT_W'($signed(cfg.a_low))) && (pa <= PT_W'($signed(cfg.a_high)))
           && (pb >= PT_W'($signed(cfg.b_low))) && (pb <= PT_W'($signed(cfg.b_high)));
    da     = pa - PT_W'($signed(cfg.a_low));
    db     = pb - PT_W'($signed(cfg.b_low));
    ext_a  = {cfg.a_high[rai_pkg::CRD_W-1], cfg.a_high}
           - {cfg.a_low[rai_pkg::CRD_W-1], cfg.a_low};
    ext_b  = {cfg.b_high[rai_pkg::CRD_W-1], cfg.b_high}
           - {cfg.b_low[rai_pkg::CRD_W-1], cfg.b_low};
    hs_nxt.hit   = !miss_c_r && in_rect;
    hs_nxt.front = front_c_r;
    hs_nxt.t     = t_c_r;
    hs_nxt.px    = sat_pt(px_c_r);
    hs_nxt.py    = sat_pt(py_c_r);
    hs_nxt.pz    = sat_pt(pz_c_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_o   <= 1'b0;
    end else begin
      vld_a_r <= vld_in;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
      vld_o   <= vld_c_r;
    end
    miss_a_r  <= side_in.miss || !in_rng;
    t_a_r     <= t_full[rai_pkg::CRD_W-1:0];
    side_a_r  <= side_in;

    miss_b_r  <= miss_a_r;
    t_b_r     <= t_a_r;
    side_b_r  <= side_a_r;
    prx_b_r   <= $signed(t_a_r) * $signed(side_a_r.dx);
    pry_b_r   <= $signed(t_a_r) * $signed(side_a_r.dy);
    prz_b_r   <= $signed(t_a_r) * $signed(side_a_r.dz);

    miss_c_r  <= miss_b_r;
    t_c_r     <= t_b_r;
    front_c_r <= side_b_r.front;
    px_c_r    <= add_pt(side_b_r.ox, prx_b_r);
    py_c_r    <= add_pt(side_b_r.oy, pry_b_r);
    pz_c_r    <= add_pt(side_b_r.oz, prz_b_r);

    hs_o      <= hs_nxt;
    xa_o      <= da[rai_pkg::CRD_W-1:0];
    xb_o      <= db[rai_pkg::CRD_W-1:0];
    ea_o      <= ext_a[rai_pkg::CRD_W-1:0];
    eb_o      <= ext_b[rai_pkg::CRD_W-1:0];
  end

endmodule

// ----- rtl/rai_texdiv.sv -----
`timescale 1ns / 1ps
module rai_texdiv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld_in,
  input  rai_pkg::hit_side_t         hs_in,
  input  logic [rai_pkg::CRD_W-1:0]  xa_in,
  input  logic [rai_pkg::CRD_W-1:0]  ea_in,
  input  logic [rai_pkg::CRD_W-1:0]  xb_in,
  input  logic [rai_pkg::CRD_W-1:0]  eb_in,
  output logic                       vld_o,
  output rai_pkg::hit_side_t         hs_o,
  output logic [rai_pkg::TEX_W-1:0]  u_o,
  output logic [rai_pkg::TEX_W-1:0]  v_o
);

  localparam int N = rai_pkg::TEX_W;

  // lane 0 is u, lane 1 is v; x <= e on a hit so the quotient fits N bits
  logic [rai_pkg::CRD_W-1:0] x_in    [2];
  logic [rai_pkg::CRD_W-1:0] e_in    [2];
  logic [N-1:0]              vld_r;
  logic [rai_pkg::CRD_W-1:0] rem_r   [N][2];
  logic [rai_pkg::CRD_W-1:0] rem_nxt [N][2];
  logic [rai_pkg::CRD_W-1:0] e_r     [N][2];
  logic [N-1:0]              q_r     [N][2];
  logic [N-1:0]              q_nxt   [N][2];
  rai_pkg::hit_side_t        hs_r    [N];

  assign x_in[0] = xa_in;
  assign x_in[1] = xb_in;
  assign e_in[0] = ea_in;
  assign e_in[1] = eb_in;

  always_comb begin
    logic [rai_pkg::CRD_W:0]   r2;
    logic [rai_pkg::CRD_W-1:0] e_i;
    logic [N-1:0]              q_i;
    logic                      ge;
    for (int i = 0; i < N; i++) begin
      for (int l = 0; l < 2; l++) begin
        if (i == 0) begin
          r2  = {1'b0, x_in[l]};
          e_i = e_in[l];
          q_i = '0;
        end else begin
          r2  = {rem_r[i-1][l], 1'b0};
          e_i = e_r[i-1][l];
          q_i = q_r[i-1][l];
        end
        ge            = r2 >= {1'b0, e_i};
        rem_nxt[i][l] = ge ? rai_pkg::CRD_W'(r2 - {1'b0, e_i}) : r2[rai_pkg::CRD_W-1:0];
        q_nxt[i][l]   = {q_i[N-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N-2:0], vld_in};
    end
    hs_r[0] <= hs_in;
    for (int l = 0; l < 2; l++) begin
      e_r[0][l] <= e_in[l];
    end
    for (int i = 1; i < N; i++) begin
      hs_r[i] <= hs_r[i-1];
      for (int l = 0; l < 2; l++) begin
        e_r[i][l] <= e_r[i-1][l];
      end
    end
    for (int i = 0; i < N; i++) begin
      for (int l = 0; l < 2; l++) begin
        rem_r[i][l] <= rem_nxt[i][l];
        q_r[i][l]   <= q_nxt[i][l];
      end
    end
  end

  assign vld_o = vld_r[N-1];
  assign hs_o  = hs_r[N-1];
  assign u_o   = q_r[N-1][0];
  assign v_o   = q_r[N-1][1];

endmodule
